// ===== rtl/core/wsp_pkg.sv =====
// shared types and constants for the wav stream header parser
// holds the byte and result word structs, parse phase enum and tag values
`timescale 1ns / 1ps

package wsp_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_JUNK = 32'h4b4e_554a;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_LEN    = 32'd16;
  localparam logic [3:0]  FMT_BODY_LAST   = 4'd15;
  localparam logic [3:0]  FMT_FORMAT_POS  = 4'd1;
  localparam logic [3:0]  FMT_CHANNEL_POS = 4'd3;
  localparam logic [3:0]  FMT_RATE_POS    = 4'd7;
  localparam logic [15:0] PCM_BITS        = 16'd16;

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID1, PH_JSIZE, PH_JSKIP, PH_ID2, PH_FSIZE,
    PH_FBODY, PH_FSKIP, PH_CID, PH_CSIZE, PH_CSKIP, PH_DSIZE, PH_DATA, PH_WAIT
  } wsp_phase_t;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_FORMAT = 2'd1,
    KIND_ERROR  = 2'd2
  } wsp_kind_t;

  typedef enum logic [2:0] {
    ERR_BAD_RIFF  = 3'd0,
    ERR_BAD_WAVE  = 3'd1,
    ERR_BAD_FMT   = 3'd2,
    ERR_NOT_16BIT = 3'd3,
    ERR_TRUNCATED = 3'd4
  } wsp_error_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_file;
  } wsp_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] samp_rate;
    logic [15:0] chan_count;
    logic [15:0] audio_format_code;
    logic [31:0] data_length;
    logic [2:0]  error_code;
    logic        last;
  } wsp_out_t;

  typedef struct packed {
    logic     valid;
    wsp_out_t item;
  } wsp_step_t;

endpackage

// ===== rtl/core/wav_stream_header_parser.sv =====
// Top level of the wav stream header parser.
// Input channel: one file byte per word (byte_valid / byte_stall / byte_word),
// with end_of_file set on the final byte of each file.
// Output channel: result words (result_valid / result_stall / result_word):
// one format-info word once the data chunk size is in, then one word per PCM
// byte (an odd trailing byte is dropped), or a single error word on any
// failure, including a file that ends early. last marks the final word of a file.
// Throughput: one byte per cycle while result_stall is low, set by the single parse stage
// between the input register and the result register.
// A byte accepted into the input register is parsed there, and its result word is
// then captured in the result register, which drives result_valid and result_word.
// Bytes that give no result (tags, sizes, skipped chunks) leave the output idle.
// Reset: synchronous, clears the full and valid flags of both stage registers and returns the parser to
// expecting a RIFF tag; end_of_file does the same for the parse state.
// Stall: while result_stall holds a waiting word, the parse stage freezes and
// byte_stall rises once the input register is also full; nothing is lost.
// depends on wsp_pkg, wsp_in_stage, wsp_parse_core, wsp_out_stage
`timescale 1ns / 1ps

module wav_stream_header_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  wsp_pkg::wsp_in_t  byte_word,
  output logic              result_valid,
  input  logic              result_stall,
  output wsp_pkg::wsp_out_t result_word
);
  import wsp_pkg::*;

  logic      in_full;
  logic      advance;
  wsp_in_t   held;
  wsp_step_t step_result;

  // parse a held byte whenever the result register is free or draining
  assign advance = in_full && (!result_valid || !result_stall);

  wsp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_word  (byte_word),
    .advance    (advance),
    .full       (in_full),
    .held       (held)
  );

  wsp_parse_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (held),
    .result (step_result)
  );

  wsp_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .step_result  (step_result),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word)
  );

endmodule

// ===== rtl/core/wsp_in_stage.sv =====
// input register for the file byte stream
// depends on wsp_pkg for the byte word struct
`timescale 1ns / 1ps

module wsp_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  wsp_pkg::wsp_in_t byte_word,
  input  logic             advance,
  output logic             full,
  output wsp_pkg::wsp_in_t held
);
  import wsp_pkg::*;

  // holding register frees up in the same cycle it is consumed
  assign byte_stall = full && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (!byte_stall) begin
      full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      held <= byte_word;
    end
  end

endmodule

// ===== rtl/core/wsp_parse_core.sv =====
// parse state machine: tag checks, chunk skipping, fmt capture and data pass-through
// depends on wsp_pkg for phase enum, tags and word structs
`timescale 1ns / 1ps

module wsp_parse_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wsp_pkg::wsp_in_t  word,
  output wsp_pkg::wsp_step_t result
);
  import wsp_pkg::*;

  wsp_phase_t  phase, phase_next, phase_body;
  logic [31:0] field_shift, field_shift_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [31:0] fmt_chunk_size, fmt_chunk_size_next;
  logic [31:0] held_sample_rate, held_sample_rate_next;
  logic [15:0] held_channels, held_channels_next;
  logic [15:0] held_format, held_format_next;
  logic [31:0] data_left, data_left_next;

  logic [31:0] shift_new;
  logic        shifting;
  logic        gather_done;
  logic        bits_bad;
  logic        fmt_has_tail;
  logic        data_odd;
  wsp_out_t    blank;

  assign shift_new    = {word.in_byte, field_shift[31:8]};
  assign shifting     = !(phase inside {PH_WAIT, PH_JSKIP, PH_FSKIP, PH_CSKIP, PH_DATA});
  assign gather_done  = (byte_position[1:0] == 2'd3);
  assign bits_bad     = (shift_new[31:16] != PCM_BITS);
  assign fmt_has_tail = (fmt_chunk_size > FMT_BODY_LEN);
  assign data_odd     = byte_position[0];
  assign blank        = '0;

  // next phase before the end-of-file override
  always_comb begin
    phase_body = phase;
    case (phase)
      PH_RIFF:  if (gather_done) phase_body = (shift_new == TAG_RIFF) ? PH_RSIZE : PH_WAIT;
      PH_RSIZE: if (gather_done) phase_body = PH_WAVE;
      PH_WAVE:  if (gather_done) phase_body = (shift_new == TAG_WAVE) ? PH_ID1 : PH_WAIT;
      PH_ID1: begin
        if (gather_done) begin
          if (shift_new == TAG_FMT) phase_body = PH_FSIZE;
          else if (shift_new == TAG_JUNK) phase_body = PH_JSIZE;
          else phase_body = PH_WAIT;
        end
      end
      PH_JSIZE: if (gather_done) phase_body = (shift_new != '0) ? PH_JSKIP : PH_ID2;
      PH_JSKIP: if (skip_remaining == 32'd1) phase_body = PH_ID2;
      PH_ID2:   if (gather_done) phase_body = (shift_new == TAG_FMT) ? PH_FSIZE : PH_WAIT;
      PH_FSIZE: if (gather_done) phase_body = PH_FBODY;
      PH_FBODY: begin
        if (byte_position == FMT_BODY_LAST) begin
          if (bits_bad) phase_body = PH_WAIT;
          else phase_body = fmt_has_tail ? PH_FSKIP : PH_CID;
        end
      end
      PH_FSKIP: if (skip_remaining == 32'd1) phase_body = PH_CID;
      PH_CID:   if (gather_done) phase_body = (shift_new == TAG_DATA) ? PH_DSIZE : PH_CSIZE;
      PH_CSIZE: if (gather_done) phase_body = (shift_new != '0) ? PH_CSKIP : PH_CID;
      PH_CSKIP: if (skip_remaining == 32'd1) phase_body = PH_CID;
      PH_DSIZE: if (gather_done) phase_body = (shift_new != '0) ? PH_DATA : PH_WAIT;
      PH_DATA:  if (data_left == 32'd1) phase_body = PH_WAIT;
      default:  phase_body = phase;
    endcase
    phase_next = word.end_of_file ? PH_RIFF : phase_body;
  end

  // datapath updates and the result word
  always_comb begin
    field_shift_next      = shifting ? shift_new : field_shift;
    byte_position_next    = byte_position;
    skip_remaining_next   = skip_remaining;
    fmt_chunk_size_next   = fmt_chunk_size;
    held_sample_rate_next = held_sample_rate;
    held_channels_next    = held_channels;
    held_format_next      = held_format;
    data_left_next        = data_left;
    result                = '0;

    case (phase)
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID1, PH_ID2, PH_CID: begin
        byte_position_next = gather_done ? 4'd0 : byte_position + 4'd1;
      end
      PH_JSIZE, PH_CSIZE: begin
        byte_position_next = gather_done ? 4'd0 : byte_position + 4'd1;
        if (gather_done) skip_remaining_next = shift_new;
      end
      PH_FSIZE: begin
        byte_position_next = gather_done ? 4'd0 : byte_position + 4'd1;
        if (gather_done) fmt_chunk_size_next = shift_new;
      end
      PH_JSKIP, PH_FSKIP, PH_CSKIP: begin
        skip_remaining_next = skip_remaining - 32'd1;
      end
      PH_FBODY: begin
        byte_position_next = byte_position + 4'd1;
        if (byte_position == FMT_FORMAT_POS) held_format_next = shift_new[31:16];
        if (byte_position == FMT_CHANNEL_POS) held_channels_next = shift_new[31:16];
        if (byte_position == FMT_RATE_POS) held_sample_rate_next = shift_new;
        if (byte_position == FMT_BODY_LAST) begin
          skip_remaining_next = fmt_has_tail ? fmt_chunk_size - FMT_BODY_LEN : '0;
        end
      end
      PH_DSIZE: begin
        byte_position_next = gather_done ? 4'd0 : byte_position + 4'd1;
        if (gather_done) data_left_next = shift_new;
      end
      PH_DATA: begin
        byte_position_next = byte_position + 4'd1;
        data_left_next     = data_left - 32'd1;
      end
      default: begin
      end
    endcase

    // result word for this byte
    result.item = blank;
    case (phase)
      PH_RIFF, PH_WAVE, PH_ID1, PH_ID2: begin
        if (gather_done && phase_body == PH_WAIT) begin
          result.valid           = 1'b1;
          result.item.kind       = KIND_ERROR;
          result.item.last       = 1'b1;
          if (phase == PH_RIFF) result.item.error_code = ERR_BAD_RIFF;
          else if (phase == PH_WAVE) result.item.error_code = ERR_BAD_WAVE;
          else result.item.error_code = ERR_BAD_FMT;
        end
      end
      PH_FBODY: begin
        if (byte_position == FMT_BODY_LAST && bits_bad) begin
          result.valid           = 1'b1;
          result.item.kind       = KIND_ERROR;
          result.item.error_code = ERR_NOT_16BIT;
          result.item.last       = 1'b1;
        end
      end
      PH_DSIZE: begin
        if (gather_done) begin
          result.valid                  = 1'b1;
          result.item.kind              = KIND_FORMAT;
          result.item.samp_rate         = held_sample_rate;
          result.item.chan_count        = held_channels;
          result.item.audio_format_code = held_format;
          result.item.data_length       = shift_new;
          result.item.last              = (shift_new < 32'd2);
        end
      end
      PH_DATA: begin
        // an unpaired final byte is dropped
        if (!(data_left == 32'd1 && !data_odd)) begin
          result.valid          = 1'b1;
          result.item.kind      = KIND_DATA;
          result.item.data_byte = word.in_byte;
          result.item.last      = data_odd && (data_left <= 32'd2);
        end
      end
      default: begin
      end
    endcase

    if (word.end_of_file) begin
      if (phase_body != PH_WAIT) begin
        result.valid           = 1'b1;
        result.item            = blank;
        result.item.kind       = KIND_ERROR;
        result.item.error_code = ERR_TRUNCATED;
        result.item.last       = 1'b1;
      end
      field_shift_next      = '0;
      byte_position_next    = '0;
      skip_remaining_next   = '0;
      fmt_chunk_size_next   = '0;
      held_sample_rate_next = '0;
      held_channels_next    = '0;
      held_format_next      = '0;
      data_left_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RIFF;
      field_shift      <= '0;
      byte_position    <= '0;
      skip_remaining   <= '0;
      fmt_chunk_size   <= '0;
      held_sample_rate <= '0;
      held_channels    <= '0;
      held_format      <= '0;
      data_left        <= '0;
    end else if (step) begin
      phase            <= phase_next;
      field_shift      <= field_shift_next;
      byte_position    <= byte_position_next;
      skip_remaining   <= skip_remaining_next;
      fmt_chunk_size   <= fmt_chunk_size_next;
      held_sample_rate <= held_sample_rate_next;
      held_channels    <= held_channels_next;
      held_format      <= held_format_next;
      data_left        <= data_left_next;
    end
  end

endmodule

// ===== rtl/core/wsp_out_stage.sv =====
// result register toward the downstream receiver
// depends on wsp_pkg for the result word structs
`timescale 1ns / 1ps

module wsp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  wsp_pkg::wsp_step_t step_result,
  output logic               result_valid,
  input  logic               result_stall,
  output wsp_pkg::wsp_out_t  result_word
);
  import wsp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= step_result.valid;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && step_result.valid) begin
      result_word <= step_result.item;
    end
  end

endmodule
